// ----- rtl/pdpd_pkg.sv -----
// Shared types, constants and pulse fit function for the pulse-distance decoder.
`default_nettype none

package pdpd_pkg;

  localparam int unsigned PACKET_BITS_DEFAULT = 56;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned NOM_W   = 16;
  localparam int unsigned TOL_W   = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 3'd4;

  // Reset values
  localparam logic [NOM_W-1:0] HIGH_PULSE_RST = 16'd500;
  localparam logic [NOM_W-1:0] SYNC_LOW_RST   = 16'd4000;
  localparam logic [NOM_W-1:0] ONE_LOW_RST    = 16'd2000;
  localparam logic [NOM_W-1:0] ZERO_LOW_RST   = 16'd1000;
  localparam logic [TOL_W-1:0] TOLERANCE_RST  = 12'd100;

  // Command codes
  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_READOUT = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT_HIGH = 2'd0,
    PH_HUNT_SYNC = 2'd1,
    PH_WAIT_GAP  = 2'd2,
    PH_MEASURE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [NOM_W-1:0] high_pulse_us;
    logic [NOM_W-1:0] sync_low_us;
    logic [NOM_W-1:0] one_low_us;
    logic [NOM_W-1:0] zero_low_us;
    logic [TOL_W-1:0] tolerance_us;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              level;
    logic [TIME_W-1:0] timestamp;
    logic              clear_flag;
  } item_t;

  // nominal - tol < dur < nominal + tol, computed without wrap
  function automatic logic fits(input logic [TIME_W-1:0] dur,
                                input logic [NOM_W-1:0] nominal,
                                input logic [TOL_W-1:0] tol);
    logic [TIME_W:0] dur_tol;
    logic [NOM_W:0]  nom_tol;
    dur_tol = {1'b0, dur} + {{(TIME_W-TOL_W+1){1'b0}}, tol};
    nom_tol = {1'b0, nominal} + {{(NOM_W-TOL_W+1){1'b0}}, tol};
    return (dur_tol > {{(TIME_W-NOM_W+1){1'b0}}, nominal}) &&
           ({1'b0, dur} < {{(TIME_W-NOM_W){1'b0}}, nom_tol});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pdpd_cfg_regs.sv -----
// Timing configuration registers with plain write port.
`default_nettype none

module pdpd_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [pdpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pdpd_pkg::CFG_DATA_W-1:0] cfg_data,
  output pdpd_pkg::cfg_t                      cfg
);
  import pdpd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_pulse_us <= HIGH_PULSE_RST;
      cfg.sync_low_us   <= SYNC_LOW_RST;
      cfg.one_low_us    <= ONE_LOW_RST;
      cfg.zero_low_us   <= ZERO_LOW_RST;
      cfg.tolerance_us  <= TOLERANCE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HIGH_PULSE: cfg.high_pulse_us <= cfg_data;
        REG_SYNC_LOW:   cfg.sync_low_us   <= cfg_data;
        REG_ONE_LOW:    cfg.one_low_us    <= cfg_data;
        REG_ZERO_LOW:   cfg.zero_low_us   <= cfg_data;
        REG_TOLERANCE:  cfg.tolerance_us  <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pdpd_in_stage.sv -----
// Input register stage: captures one word, holds it until the engine takes it.
`default_nettype none

module pdpd_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        cmd,
  input  wire logic                        level,
  input  wire logic [pdpd_pkg::TIME_W-1:0] timestamp,
  input  wire logic                        clear_flag,
  output logic                             held_valid,
  output pdpd_pkg::item_t                  held,
  input  wire logic                        take
);
  import pdpd_pkg::*;

  logic load;

  // stall only when a word is held and the engine cannot take it
  assign item_stall = held_valid && !take;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held.cmd        <= cmd;
      held.level      <= level;
      held.timestamp  <= timestamp;
      held.clear_flag <= clear_flag;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pdpd_engine.sv -----
// Decoder state and result register: one word processed per cycle unless the result side stalls.
`default_nettype none

module pdpd_engine #(
  parameter int unsigned PACKET_BITS = pdpd_pkg::PACKET_BITS_DEFAULT,
  localparam int unsigned CNT_W = $clog2(PACKET_BITS + 1),
  localparam int unsigned POS_W = $clog2(PACKET_BITS)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  pdpd_pkg::cfg_t        cfg,
  input  wire logic             held_valid,
  input  pdpd_pkg::item_t       held,
  output logic                  take,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [PACKET_BITS-1:0] packet_bits,
  output logic [CNT_W-1:0]      bit_count,
  output logic                  has_data,
  output logic                  enabled,
  output logic                  packet_done
);
  import pdpd_pkg::*;

  // Decoder state; it doubles as the result register since it only moves on take
  phase_t                 phase, phase_next;
  logic [TIME_W-1:0]      last_time, last_time_next;
  logic [PACKET_BITS-1:0] shift_bits, shift_next;
  logic [CNT_W-1:0]       count, count_next;
  logic                   on, on_next;
  logic                   ready, ready_next;
  logic                   done_next;

  logic              edge_ev;
  logic [TIME_W-1:0] dur;
  logic              fit_high, fit_sync, fit_one, fit_zero;
  logic              bit_take;
  logic [CNT_W-1:0]  count_after;
  logic              full_after;
  logic [POS_W-1:0]  bit_pos;

  assign take    = held_valid && (!result_valid || !result_stall);
  assign edge_ev = take && (held.cmd == CMD_EDGE) && on;
  assign dur     = held.timestamp - last_time;

  assign fit_high = fits(dur, cfg.high_pulse_us, cfg.tolerance_us);
  assign fit_sync = fits(dur, cfg.sync_low_us,   cfg.tolerance_us);
  assign fit_one  = fits(dur, cfg.one_low_us,    cfg.tolerance_us);
  assign fit_zero = fits(dur, cfg.zero_low_us,   cfg.tolerance_us);

  assign bit_take    = count < CNT_W'(PACKET_BITS);
  assign count_after = bit_take ? count + CNT_W'(1) : count;
  assign full_after  = count_after >= CNT_W'(PACKET_BITS);
  // count < PACKET_BITS whenever a bit is stored, so the low bits suffice
  assign bit_pos     = POS_W'(PACKET_BITS - 1) - count[POS_W-1:0];

  // next phase
  always_comb begin
    phase_next = phase;
    if (edge_ev) begin
      unique case (phase)
        PH_HUNT_HIGH: begin
          if (!held.level) phase_next = fit_high ? PH_HUNT_SYNC : PH_HUNT_HIGH;
        end
        PH_HUNT_SYNC: begin
          if (held.level) phase_next = fit_sync ? PH_WAIT_GAP : PH_HUNT_HIGH;
        end
        PH_WAIT_GAP: begin
          if (!held.level) phase_next = PH_MEASURE;
        end
        PH_MEASURE: begin
          if (held.level) begin
            if ((fit_zero || fit_one) && !full_after) phase_next = PH_WAIT_GAP;
            else                                      phase_next = PH_HUNT_HIGH;
          end
        end
        default: phase_next = PH_HUNT_HIGH;
      endcase
    end
  end

  // data path and flags
  always_comb begin
    last_time_next = last_time;
    shift_next     = shift_bits;
    count_next     = count;
    on_next        = on;
    ready_next     = ready;
    done_next      = 1'b0;
    if (take && (held.cmd == CMD_READOUT)) begin
      if (held.clear_flag) ready_next = 1'b0;
      on_next = 1'b1;
    end
    if (edge_ev) begin
      last_time_next = held.timestamp;
      if ((phase == PH_HUNT_SYNC) && held.level && fit_sync) begin
        shift_next = '0;
        count_next = '0;
      end
      if ((phase == PH_MEASURE) && held.level && (fit_zero || fit_one)) begin
        // zero fit wins over one fit
        if (bit_take && !fit_zero)
          shift_next = shift_bits | ({{(PACKET_BITS-1){1'b0}}, 1'b1} << bit_pos);
        count_next = count_after;
        if (full_after) begin
          on_next    = 1'b0;
          ready_next = 1'b1;
          done_next  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT_HIGH;
      last_time    <= '0;
      shift_bits   <= '0;
      count        <= '0;
      on           <= 1'b1;
      ready        <= 1'b0;
      packet_done  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        phase       <= phase_next;
        last_time   <= last_time_next;
        shift_bits  <= shift_next;
        count       <= count_next;
        on          <= on_next;
        ready       <= ready_next;
        packet_done <= done_next;
      end
      if (take)              result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  assign packet_bits = shift_bits;
  assign bit_count   = count;
  assign has_data    = ready;
  assign enabled     = on;

endmodule

`default_nettype wire

// ----- rtl/pulse_distance_packet_decoder_core.sv -----
// Top level of the pulse-distance packet decoder.
`default_nettype none

// Pulse-distance packet decoder. Each input word is either a receiver edge
// (cmd = 0: new level plus 32-bit microsecond timestamp) or a read-out
// (cmd = 1). Every accepted word yields exactly one result word carrying the
// decoder state after that word: packet bits (first bit in the MSB), bit
// count, has-data flag, enable, and a packet_done marker for the edge that
// completed a packet. Timing: one word per clock sustained while the result
// side does not stall; each word passes the input register, then the
// decoder state register, which also serves as the result register. The
// critical path is the 32-bit duration subtract feeding four parallel
// add/compare windows. Pulse lengths are matched with an exclusive window
// of +/- tolerance_us around each nominal. A completed packet disables the
// decoder until a read-out; edges seen while disabled are dropped,
// timestamp included. Configuration is written through cfg_write/cfg_index/
// cfg_data (index 0..4: high pulse, sync low, one low, zero low, tolerance)
// and must only change while no words are in flight.
module pulse_distance_packet_decoder_core #(
  parameter int unsigned PACKET_BITS = pdpd_pkg::PACKET_BITS_DEFAULT,
  localparam int unsigned CNT_W = $clog2(PACKET_BITS + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_write,
  input  wire logic [pdpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pdpd_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic                            cmd,
  input  wire logic                            level,
  input  wire logic [pdpd_pkg::TIME_W-1:0]     timestamp,
  input  wire logic                            clear_flag,
  // result words
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic [PACKET_BITS-1:0]               packet_bits,
  output logic [CNT_W-1:0]                     bit_count,
  output logic                                 has_data,
  output logic                                 enabled,
  output logic                                 packet_done
);
  import pdpd_pkg::*;

  cfg_t  cfg;
  item_t held;
  logic  held_valid;
  logic  take;

  pdpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // word register in front of the decoder
  pdpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .level      (level),
    .timestamp  (timestamp),
    .clear_flag (clear_flag),
    .held_valid (held_valid),
    .held       (held),
    .take       (take)
  );

  // phase tracking, bit assembly and result hold
  pdpd_engine #(
    .PACKET_BITS (PACKET_BITS)
  ) u_eng (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .held_valid   (held_valid),
    .held         (held),
    .take         (take),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .packet_bits  (packet_bits),
    .bit_count    (bit_count),
    .has_data     (has_data),
    .enabled      (enabled),
    .packet_done  (packet_done)
  );

endmodule

`default_nettype wire

// ----- rtl/pdpd_checker.sv -----
// Port-level checks for the pulse-distance decoder, bound to the top level.
`default_nettype none

module pdpd_checker #(
  parameter int unsigned PACKET_BITS = pdpd_pkg::PACKET_BITS_DEFAULT,
  localparam int unsigned CNT_W = $clog2(PACKET_BITS + 1)
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   result_valid,
  input wire logic                   result_stall,
  input wire logic [PACKET_BITS-1:0] packet_bits,
  input wire logic [CNT_W-1:0]       bit_count,
  input wire logic                   has_data,
  input wire logic                   enabled,
  input wire logic                   packet_done
);

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(packet_bits) && $stable(bit_count) &&
      $stable(packet_done))
    else $error("result word changed while stalled");

  // a completing edge leaves a full, flagged, disabled decoder
  a_done_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && packet_done |->
      !enabled && has_data && (bit_count == CNT_W'(PACKET_BITS)))
    else $error("packet_done without full packet state");

  // only a completed packet disables the decoder
  a_off_has_data: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> has_data)
    else $error("decoder disabled without pending packet");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bit_count <= CNT_W'(PACKET_BITS))
    else $error("bit count beyond packet length");

endmodule

bind pulse_distance_packet_decoder_core pdpd_checker #(
  .PACKET_BITS (PACKET_BITS)
) u_pdpd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .packet_bits  (packet_bits),
  .bit_count    (bit_count),
  .has_data     (has_data),
  .enabled      (enabled),
  .packet_done  (packet_done)
);

`default_nettype wire

// ----- tb/sv/pdpd_decode_monitor.sv -----
// Channel monitor for the pulse-distance decoder: predicts every result word and compares.
module pdpd_decode_monitor #(
  parameter int unsigned PKT_BITS = pdpd_pkg::PACKET_BITS_DEFAULT,
  parameter int unsigned CNT_W = $clog2(PKT_BITS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pdpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  logic                            cmd,
  input  logic                            level,
  input  logic [pdpd_pkg::TIME_W-1:0]     timestamp,
  input  logic                            clear_flag,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [PKT_BITS-1:0]             packet_bits,
  input  logic [CNT_W-1:0]                bit_count,
  input  logic                            has_data,
  input  logic                            enabled,
  input  logic                            packet_done,
  output int                              errors,
  output int                              pending,
  output int                              checked,
  output int                              packets
);
  import pdpd_pkg::*;

  localparam int unsigned POS_W = $clog2(PKT_BITS);

  typedef struct packed {
    logic [PKT_BITS-1:0] bits;
    logic [CNT_W-1:0]    count;
    logic                ready;
    logic                on;
    logic                done;
  } decoded_t;

  decoded_t predicted_words[$];

  cfg_t                regs;
  logic [TIME_W-1:0]   last_ts;
  phase_t              ph;
  logic [PKT_BITS-1:0] shift_reg;
  logic [CNT_W-1:0]    nbits;
  logic                dec_on;
  logic                ready;

  initial begin
    errors = 0;
    pending = 0;
    checked = 0;
    packets = 0;
  end

  function automatic void reset_model();
    regs.high_pulse_us = HIGH_PULSE_RST;
    regs.sync_low_us   = SYNC_LOW_RST;
    regs.one_low_us    = ONE_LOW_RST;
    regs.zero_low_us   = ZERO_LOW_RST;
    regs.tolerance_us  = TOLERANCE_RST;
    last_ts   = '0;
    ph        = PH_HUNT_HIGH;
    shift_reg = '0;
    nbits     = '0;
    dec_on    = 1'b1;
    ready     = 1'b0;
    predicted_words.delete();
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_HIGH_PULSE: regs.high_pulse_us = data;
      REG_SYNC_LOW:   regs.sync_low_us   = data;
      REG_ONE_LOW:    regs.one_low_us    = data;
      REG_ZERO_LOW:   regs.zero_low_us   = data;
      REG_TOLERANCE:  regs.tolerance_us  = data[TOL_W-1:0];
      default: ;
    endcase
  endfunction

  // Exclusive window, evaluated wide so nothing wraps.
  function automatic logic in_window(input logic [TIME_W-1:0] dur,
                                     input logic [NOM_W-1:0] nom);
    longint d, n, t;
    d = longint'(dur);
    n = longint'(nom);
    t = longint'(regs.tolerance_us);
    return (d + t > n) && (d < n + t);
  endfunction

  function automatic decoded_t decode_word(input logic c, input logic lv,
                                           input logic [TIME_W-1:0] ts,
                                           input logic clr);
    logic [TIME_W-1:0] dur;
    logic              good;
    logic              one;
    logic              done;
    decoded_t          res;
    done = 1'b0;
    if (c == CMD_READOUT) begin
      if (clr)
        ready = 1'b0;
      dec_on = 1'b1;
    end else if (dec_on) begin
      dur = ts - last_ts;
      last_ts = ts;
      case (ph)
        PH_HUNT_HIGH: begin
          if (!lv)
            ph = in_window(dur, regs.high_pulse_us) ? PH_HUNT_SYNC : PH_HUNT_HIGH;
        end
        PH_HUNT_SYNC: begin
          if (lv) begin
            if (in_window(dur, regs.sync_low_us)) begin
              ph = PH_WAIT_GAP;
              shift_reg = '0;
              nbits = '0;
            end else begin
              ph = PH_HUNT_HIGH;
            end
          end
        end
        PH_WAIT_GAP: begin
          if (!lv)
            ph = PH_MEASURE;
        end
        default: begin
          if (lv) begin
            good = 1'b1;
            one = 1'b0;
            if (in_window(dur, regs.zero_low_us))
              one = 1'b0;
            else if (in_window(dur, regs.one_low_us))
              one = 1'b1;
            else
              good = 1'b0;
            if (!good) begin
              ph = PH_HUNT_HIGH;
            end else begin
              if (nbits < CNT_W'(PKT_BITS)) begin
                if (one)
                  shift_reg[POS_W'(PKT_BITS - 1 - nbits)] = 1'b1;
                nbits = nbits + CNT_W'(1);
              end
              ph = PH_WAIT_GAP;
              if (nbits >= CNT_W'(PKT_BITS)) begin
                dec_on = 1'b0;
                ready = 1'b1;
                done = 1'b1;
                ph = PH_HUNT_HIGH;
              end
            end
          end
        end
      endcase
    end
    res.bits  = shift_reg;
    res.count = nbits;
    res.ready = ready;
    res.on    = dec_on;
    res.done  = done;
    return res;
  endfunction

  function automatic void field_check(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor_step
    decoded_t want;
    if (rst) begin
      reset_model();
    end else begin
      // result side first: a word accepted on this edge cannot be answered yet
      if (result_valid && !result_stall) begin
        if (predicted_words.size() == 0) begin
          errors++;
          $display("%0t mismatch: result word with nothing expected, bits %0h",
                   $time, packet_bits);
        end else begin
          want = predicted_words.pop_front();
          field_check("packet_bits", 64'(want.bits), 64'(packet_bits));
          field_check("bit_count", 64'(want.count), 64'(bit_count));
          field_check("has_data", 64'(want.ready), 64'(has_data));
          field_check("enabled", 64'(want.on), 64'(enabled));
          field_check("packet_done", 64'(want.done), 64'(packet_done));
          checked++;
          if (want.done)
            packets++;
        end
      end
      if (cfg_write)
        apply_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall)
        predicted_words.push_back(decode_word(cmd, level, timestamp, clear_flag));
    end
    pending = predicted_words.size();
  end

endmodule

// ----- tb/sv/pulse_distance_packet_decoder_core_tb.sv -----
// Top testbench for the pulse-distance packet decoder: stimulus, idling and verdict.
module pulse_distance_packet_decoder_core_tb;
  import pdpd_pkg::*;

  localparam int unsigned PKT_BITS = PACKET_BITS_DEFAULT;
  localparam int unsigned CNT_W = $clog2(PKT_BITS + 1);
  localparam int CYCLE_LIMIT = 600000;   // watchdog bound for the whole run
  localparam int HOLD_CYCLES = 80;       // long receiver hold, fills the pipe
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // no register behind it

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  logic                  cmd = CMD_EDGE;
  logic                  level = 1'b0;
  logic [TIME_W-1:0]     timestamp = '0;
  logic                  clear_flag = 1'b0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [PKT_BITS-1:0]   packet_bits;
  logic [CNT_W-1:0]      bit_count;
  logic                  has_data;
  logic                  enabled;
  logic                  packet_done;

  int errors, pending, checked, packets;

  // Handshake outcome of the last rising edge, read back at the falling edge
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  logic quiet_mode = 1'b0;   // no idling on either side while set
  logic hold_req = 1'b0;     // asks the receiver for one long hold
  int   words_sent = 0;
  int   settings_run = 0;
  logic [TIME_W-1:0] now_us = '0;   // running receiver time for well-formed edges

  // Current nominals, mirrored so the stimulus can aim inside or outside windows
  int high_n, sync_n, one_n, zero_n, tol_n;

  pulse_distance_packet_decoder_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .level(level), .timestamp(timestamp), .clear_flag(clear_flag),
    .result_valid(result_valid), .result_stall(result_stall),
    .packet_bits(packet_bits), .bit_count(bit_count), .has_data(has_data),
    .enabled(enabled), .packet_done(packet_done)
  );

  pdpd_decode_monitor #(.PKT_BITS(PKT_BITS)) decode_mon (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .cmd(cmd), .level(level), .timestamp(timestamp), .clear_flag(clear_flag),
    .result_valid(result_valid), .result_stall(result_stall),
    .packet_bits(packet_bits), .bit_count(bit_count), .has_data(has_data),
    .enabled(enabled), .packet_done(packet_done),
    .errors(errors), .pending(pending), .checked(checked), .packets(packets)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_fire  <= item_valid && !item_stall;
    out_fire <= result_valid && !result_stall;
  end

  // Watchdog: a hang or a lost result word ends here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Random single bit for level and flag fields
  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one word after a random gap; hold it steady until accepted.
  task automatic push_word(input logic c, input logic lv, input logic [TIME_W-1:0] ts,
                           input logic clr);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    cmd = c;
    level = lv;
    timestamp = ts;
    clear_flag = clr;
    do @(negedge clk); while (!in_fire);
    words_sent++;
  endtask

  // Edge event dur microseconds after the previous one; clear_flag is don't-care here
  task automatic send_edge(input logic lv, input int dur);
    now_us = now_us + dur;
    push_word(CMD_EDGE, lv, now_us, coin());
  endtask

  task automatic readout(input logic clr);
    push_word(CMD_READOUT, coin(), $urandom, clr);
  endtask

  // Drain: wait until nothing is in flight, then let the two-stage pipe empty
  task automatic settle();
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(data);
    @(negedge clk);
  endtask

  // Registers only change with the decoder idle
  task automatic load_settings(input int h, input int s, input int o, input int z,
                               input int t);
    settle();
    write_reg(REG_HIGH_PULSE, h);
    write_reg(REG_SYNC_LOW, s);
    write_reg(REG_ONE_LOW, o);
    write_reg(REG_ZERO_LOW, z);
    write_reg(REG_TOLERANCE, t);
    write_reg(REG_UNUSED, $urandom);   // must be dropped
    cfg_write = 1'b0;
    high_n = h;
    sync_n = s;
    one_n = o;
    zero_n = z;
    tol_n = t;
    settings_run++;
  endtask

  // A duration strictly inside the window around nom (nom itself if tolerance is 0)
  function automatic int pick_fit(input int nom);
    int lo, hi;
    if (tol_n == 0)
      return nom;
    lo = nom - tol_n + 1;
    if (lo < 0)
      lo = 0;
    hi = nom + tol_n - 1;
    return $urandom_range(hi, lo);
  endfunction

  // A bad bit gap: window edges (exclusive, so they miss) or anything at all
  function automatic int pick_miss();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 200000);
      1: return one_n + tol_n;
      default: return (zero_n >= tol_n) ? zero_n - tol_n : zero_n + tol_n;
    endcase
  endfunction

  // Sync then nb bits; corrupt spoils the last bit gap.
  task automatic send_packet(input int nb, input logic corrupt);
    send_edge(1'b1, $urandom_range(1, 3000));
    send_edge(1'b0, pick_fit(high_n));
    send_edge(1'b1, pick_fit(sync_n));
    for (int i = 0; i < nb; i++) begin
      send_edge(1'b0, pick_fit(high_n));   // gap start, any timing
      if ($urandom_range(0, 39) == 0)
        readout(coin());                   // peek mid-packet
      if (corrupt && i == nb - 1)
        send_edge(1'b1, pick_miss());
      else
        send_edge(1'b1, pick_fit($urandom_range(0, 1) ? one_n : zero_n));
    end
    if (!corrupt && nb == PKT_BITS) begin
      // decoder is now off: these edges must be dropped, timestamp too
      repeat ($urandom_range(0, 3))
        send_edge(coin(), $urandom_range(0, 9000));
      // sometimes leave it unread so the next packet hits a disabled decoder
      if ($urandom_range(0, 4) != 0)
        readout(coin());
    end
  endtask

  task automatic send_noise(input int n);
    int nom;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: nom = high_n;
        1: nom = sync_n;
        2: nom = one_n;
        default: nom = zero_n;
      endcase
      case ($urandom_range(0, 4))
        0: readout(coin());
        1: begin
          now_us = $urandom;
          push_word(CMD_EDGE, coin(), now_us, coin());
        end
        2: send_edge(coin(), $urandom_range(0, 70000));
        3: send_edge(coin(), pick_fit(nom));
        default: send_edge(coin(), pick_miss());
      endcase
    end
  endtask

  // Mostly clean packets with random bits; the rest broken packets and noise
  task automatic run_random(input int target);
    int sel;
    now_us = $urandom;
    while (words_sent < target) begin
      quiet_mode = ($urandom_range(0, 4) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 65)
        send_packet(PKT_BITS, 1'b0);
      else if (sel < 85)
        send_packet($urandom_range(1, PKT_BITS), 1'b1);
      else
        send_noise($urandom_range(1, 12));
    end
    quiet_mode = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall per word, plus the long hold on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int w;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      w = quiet_mode ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        result_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(negedge clk); while (!out_fire);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int t;
    high_n = int'(HIGH_PULSE_RST);
    sync_n = int'(SYNC_LOW_RST);
    one_n  = int'(ONE_LOW_RST);
    zero_n = int'(ZERO_LOW_RST);
    tol_n  = int'(TOLERANCE_RST);
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Directed words on reset settings
    push_word(CMD_EDGE, 1'b0, 32'h0000_0000, 1'b0);     // zero duration: no fit
    push_word(CMD_EDGE, 1'b1, 32'hFFFF_FFFF, 1'b1);     // high while hunting: time only
    push_word(CMD_READOUT, 1'b1, 32'hFFFF_FFFF, 1'b1);  // read-out with nothing held
    push_word(CMD_EDGE, 1'b0, 32'h0000_01F3, 1'b0);     // wraps, exactly nominal high
    now_us = 32'h0000_01F3;
    send_edge(1'b0, 10);                    // low while hunting sync low: time only
    send_edge(1'b1, sync_n - tol_n);        // sync on its lower window edge: miss
    send_edge(1'b0, high_n - tol_n + 1);    // just inside high window
    send_edge(1'b1, sync_n + tol_n - 1);    // just inside sync window, bits cleared
    send_edge(1'b1, 50);                    // high while waiting for a gap
    send_edge(1'b0, high_n);
    send_edge(1'b0, 30);                    // low while measuring
    send_edge(1'b1, zero_n - tol_n + 1);    // zero bit
    send_edge(1'b0, high_n);
    send_edge(1'b1, one_n + tol_n - 1);     // one bit
    readout(1'b0);                          // read-out in mid-packet
    send_edge(1'b0, high_n);
    send_edge(1'b1, one_n + tol_n);         // upper window edge: back to hunting, bits kept
    readout(1'b1);
    send_edge(1'b0, high_n + tol_n);        // high on its upper window edge: miss
    settle();

    // Random phases across several register settings
    hold_req = 1'b1;
    run_random(600);
    load_settings(50, 400, 200, 100, 20);
    run_random(1100);
    load_settings(0, 16'hFFFF, 16'hFFFF, 0, 12'hFFF);   // extremes, widest tolerance
    run_random(1500);
    load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), 0);  // nothing fits
    run_random(1600);
    t = $urandom_range(1, 4095);
    load_settings($urandom_range(65535, t), $urandom_range(65535, t),
                  $urandom_range(65535, t), $urandom_range(65535, t), t);
    hold_req = 1'b1;
    run_random(2100);
    settle();

    $display("tb: %0d words over %0d register settings, %0d result words checked",
             words_sent, settings_run, checked);
    $display("tb: %0d complete packets decoded, %0d mismatches", packets, errors);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
